/* rtl/tun_pkg.sv */
// Shared constants and width helpers for the triangle unit normal block.
// No dependencies; every other file in rtl imports this package.
package tun_pkg;

  localparam int NUM_COORDS = 9;
  localparam int OUT_W      = 32;
  localparam int QUO_W      = 63;
  localparam int ROOT_W     = 32;
  localparam int SRW        = 36;
  localparam int PASS_SHIFT = 6;

  localparam logic [63:0] LOW_THR = 64'd281474977;
  localparam logic [63:0] ONE_LO  = 64'd281474695235680;
  localparam logic [63:0] ONE_HI  = 64'd281475258185632;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  localparam int LANE_LAT = QUO_W + ROOT_W + 1;

  function automatic int mag_width(input int cw);
    return 2 * cw + 2;
  endfunction

  function automatic int sum_width(input int cw);
    return 4 * cw + 6;
  endfunction

  function automatic int pay_width(input int cw);
    return 2 + sum_width(cw) + 3 + 3 * mag_width(cw) + 3 * (2 * mag_width(cw));
  endfunction

endpackage

/* rtl/tun_front.sv */
// Front end: edge vectors, cross product, squared lengths and classification.
// Depends on tun_pkg; feeds tun_fifo.
module tun_front import tun_pkg::*; #(
  parameter int CW  = 16,
  parameter int PLW = pay_width(16)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [NUM_COORDS*CW-1:0] in_data_i,
  input  logic                     full_i,
  output logic                     push_o,
  output logic [PLW-1:0]           pay_o
);

  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int CRW = PW + 1;
  localparam int MW  = mag_width(CW);
  localparam int SQW = 2 * MW;
  localparam int SW  = sum_width(CW);

  logic [4:0] v_q;
  logic       en;

  logic signed [EW-1:0]  e0_q [3];
  logic signed [EW-1:0]  e1_q [3];
  logic signed [PW-1:0]  pt_q [3];
  logic signed [PW-1:0]  pu_q [3];
  logic [2:0]            neg3_q, neg4_q, neg5_q;
  logic [MW-1:0]         mag3_q [3];
  logic [MW-1:0]         mag4_q [3];
  logic [MW-1:0]         mag5_q [3];
  logic [SQW-1:0]        msq4_q [3];
  logic [SQW-1:0]        msq5_q [3];
  logic [SW-1:0]         s_q;
  logic                  ok_q, pass_q;
  logic [SW-1:0]         s_d;
  logic                  ok_d;

  assign en         = !v_q[4] || !full_i;
  assign in_ready_o = en;
  assign push_o     = v_q[4] && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int P = (i + 1) % 3;
    localparam int Q = (i + 2) % 3;
    logic signed [CW-1:0]  av, bv, cv;
    logic signed [CRW-1:0] c;

    assign av = in_data_i[i*CW +: CW];
    assign bv = in_data_i[(3+i)*CW +: CW];
    assign cv = in_data_i[(6+i)*CW +: CW];
    assign c  = CRW'(pt_q[i]) - CRW'(pu_q[i]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        e0_q[i]   <= EW'(bv) - EW'(av);
        e1_q[i]   <= EW'(cv) - EW'(av);
        pt_q[i]   <= e0_q[P] * e1_q[Q];
        pu_q[i]   <= e0_q[Q] * e1_q[P];
        neg3_q[i] <= c[CRW-1];
        mag3_q[i] <= c[CRW-1] ? MW'(-c) : MW'(c);
        neg4_q[i] <= neg3_q[i];
        mag4_q[i] <= mag3_q[i];
        msq4_q[i] <= mag3_q[i] * mag3_q[i];
        neg5_q[i] <= neg4_q[i];
        mag5_q[i] <= mag4_q[i];
        msq5_q[i] <= msq4_q[i];
      end
    end
  end

  assign s_d  = SW'(msq4_q[0]) + SW'(msq4_q[1]) + SW'(msq4_q[2]);
  assign ok_d = s_d >= SW'(LOW_THR);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q    <= s_d;
      ok_q   <= ok_d;
      pass_q <= !ok_d || (s_d >= SW'(ONE_LO) && s_d <= SW'(ONE_HI));
    end
  end

  assign pay_o = {pass_q, ok_q, s_q, neg5_q,
                  mag5_q[2], mag5_q[1], mag5_q[0],
                  msq5_q[2], msq5_q[1], msq5_q[0]};

endmodule

/* rtl/tun_fifo.sv */
// Small queue that decouples the front end from the divide/root back end.
// Depends on tun_pkg.
module tun_fifo import tun_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

/* rtl/tun_lane.sv */
// One normal component: pipelined restoring divide, pipelined bit-per-stage square root,
// rounding and saturation. Depends on tun_pkg; used by tun_back.
module tun_lane import tun_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [2*mag_width(CW)-1:0] msq_i,
  input  logic [sum_width(CW)-1:0]   s_i,
  input  logic [mag_width(CW)-1:0]   mag_i,
  input  logic                       neg_i,
  input  logic                       pass_i,
  output logic [OUT_W-1:0]           norm_o
);

  localparam int MW  = mag_width(CW);
  localparam int SW  = sum_width(CW);
  localparam int ND  = QUO_W - 1;
  localparam int NS  = ROOT_W;
  localparam int NT  = ND + NS + 1;
  localparam int PXW = (MW + PASS_SHIFT > OUT_W + 1) ? MW + PASS_SHIFT : OUT_W + 1;

  logic [SW-1:0]     dr_q [ND+1];
  logic [QUO_W-1:0]  dq_q [ND+1];
  logic [SW-1:0]     ds_q [ND+1];
  logic [2*ROOT_W-1:0] sd_q [NS];
  logic [SRW-1:0]    sr_q [NS];
  logic [ROOT_W-1:0] rt_q [NS];
  logic [MW-1:0]     mag_q [NT];
  logic              neg_q [NT];
  logic              pass_q [NT];
  logic [OUT_W-1:0]  norm_q;

  logic [SW-1:0] msq_ext;
  logic          ge0;

  assign msq_ext = SW'(msq_i);
  assign ge0     = msq_ext >= s_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dr_q[0]   <= ge0 ? msq_ext - s_i : msq_ext;
      dq_q[0]   <= QUO_W'(ge0);
      ds_q[0]   <= s_i;
      mag_q[0]  <= mag_i;
      neg_q[0]  <= neg_i;
      pass_q[0] <= pass_i;
    end
  end

  for (genvar k = 1; k < NT; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q[k]  <= mag_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        pass_q[k] <= pass_q[k-1];
      end
    end
  end

  for (genvar k = 1; k <= ND; k++) begin : g_div
    logic [SW:0] r2, sx;
    logic        ge;
    assign r2 = {dr_q[k-1], 1'b0};
    assign sx = {1'b0, ds_q[k-1]};
    assign ge = r2 >= sx;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[k] <= SW'(ge ? r2 - sx : r2);
        dq_q[k] <= {dq_q[k-1][QUO_W-2:0], ge};
        ds_q[k] <= ds_q[k-1];
      end
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    logic [2*ROOT_W-1:0] d;
    logic [SRW-1:0]      rm, cand, t;
    logic [ROOT_W-1:0]   rt;
    logic                ge;
    if (j == 0) begin : g_first
      assign d  = {1'b0, dq_q[ND]};
      assign rm = '0;
      assign rt = '0;
    end else begin : g_next
      assign d  = sd_q[j-1];
      assign rm = sr_q[j-1];
      assign rt = rt_q[j-1];
    end
    assign cand = {rm[SRW-3:0], d[2*ROOT_W-1 -: 2]};
    assign t    = {2'b00, rt, 2'b01};
    assign ge   = cand >= t;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[j] <= {d[2*ROOT_W-3:0], 2'b00};
        sr_q[j] <= ge ? cand - t : cand;
        rt_q[j] <= {rt[ROOT_W-2:0], ge};
      end
    end
  end

  logic [ROOT_W:0]  qs;
  logic [OUT_W-1:0] q;
  logic [PXW-1:0]   px;
  logic [OUT_W-1:0] sat;

  assign qs = {1'b0, rt_q[NS-1]} + 1'b1;
  assign q  = qs[ROOT_W:1];
  assign px = PXW'(mag_q[NT-1]) << PASS_SHIFT;

  always_comb begin
    if (!neg_q[NT-1]) begin
      sat = (px > PXW'(SAT_POS)) ? SAT_POS : px[OUT_W-1:0];
    end else begin
      sat = (px > PXW'(SAT_NEG)) ? SAT_NEG : -px[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q <= pass_q[NT-1] ? sat : (neg_q[NT-1] ? -q : q);
    end
  end

  assign norm_o = norm_q;

endmodule

/* rtl/tun_back.sv */
// Back end: pops classified items, runs three component lanes in lockstep
// and tracks the valid and ok flags. Depends on tun_pkg and tun_lane.
module tun_back import tun_pkg::*; #(
  parameter int CW  = 16,
  parameter int PLW = pay_width(16)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  logic [PLW-1:0]     pay_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3*OUT_W-1:0] out_data_o,
  output logic               out_ok_o
);

  localparam int MW  = mag_width(CW);
  localparam int SQW = 2 * MW;
  localparam int SW  = sum_width(CW);

  logic [LANE_LAT-1:0] v_q;
  logic [LANE_LAT-1:0] ok_q;
  logic                en;
  logic                pass;
  logic                ok;
  logic [SW-1:0]       s;
  logic [2:0]          neg;

  assign en    = !v_q[LANE_LAT-1] || out_ready_i;
  assign pop_o = en && !empty_i;

  assign {pass, ok, s, neg} = pay_i[PLW-1 -: 2 + SW + 3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LANE_LAT-2:0], !empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= {ok_q[LANE_LAT-2:0], ok};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_comp
    tun_lane #(.CW(CW)) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .msq_i  (pay_i[i*SQW +: SQW]),
      .s_i    (s),
      .mag_i  (pay_i[3*SQW + i*MW +: MW]),
      .neg_i  (neg[i]),
      .pass_i (pass),
      .norm_o (out_data_o[i*OUT_W +: OUT_W])
    );
  end

  assign out_valid_o = v_q[LANE_LAT-1];
  assign out_ok_o    = ok_q[LANE_LAT-1];

endmodule

/* rtl/triangle_unit_normal_top.sv */
// Top level of the triangle unit normal block: front end, queue, back end.
// Depends on tun_pkg, tun_front, tun_fifo, tun_back.
//
//  channel   dir  tdata (low bit up)                         tuser
//  s_axis    in   a_x a_y a_z b_x b_y b_z c_x c_y c_z       -
//  m_axis    out  norm_x norm_y norm_z (32 bits each)        ok
//
// One triangle per cycle sustained while m_axis is ready; each passes the front
// stages, the queue and the back end (63-step restoring divide plus 32-step
// square root plus rounding, one bit per stage in each of three lanes).
// Reset clears valids, queue pointers and the queue count only.
// A stall at m_axis freezes the back end; the front end keeps accepting
// until the queue fills.
module triangle_unit_normal_top import tun_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int FIFO_DEPTH  = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [((NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // norm_x, norm_y, norm_z
  output logic [3*OUT_W-1:0]  m_axis_tdata,
  // ok
  output logic                m_axis_tuser
);

  localparam int PLW = pay_width(COORD_WIDTH);

  logic           push, pop, full, empty;
  logic [PLW-1:0] pay_in, pay_out;

  tun_front #(.CW(COORD_WIDTH), .PLW(PLW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[NUM_COORDS*COORD_WIDTH-1:0]),
    .full_i     (full),
    .push_o     (push),
    .pay_o      (pay_in)
  );

  tun_fifo #(.W(PLW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pay_in),
    .pop_i   (pop),
    .data_o  (pay_out),
    .full_o  (full),
    .empty_o (empty)
  );

  tun_back #(.CW(COORD_WIDTH), .PLW(PLW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pay_i       (pay_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_ok_o    (m_axis_tuser)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for triangle_unit_normal_top: streams triangles in, checks each normal.
// Depends on tun_pkg and the block's RTL; expectations come from a predictor or typed rows.
module tb;
  import tun_pkg::*;

  localparam int CW = 16;
  localparam int DW = ((NUM_COORDS * CW + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic [OUT_W-1:0] n[3];
    logic             ok;
  } normal_t;

  typedef struct {
    logic signed [CW-1:0] p[9];
    bit                   typed;
    normal_t              want;
  } tri_row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [DW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [3*OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  normal_t  normals_due[$];
  tri_row_t directed[$];
  int fail_cnt, sent_cnt, got_cnt, idle_cnt;
  int send_idle_pct, recv_stall_pct;
  int degen_cnt, unit_cnt;
  bit hold_req;

  triangle_unit_normal_top #(.COORD_WIDTH(CW)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic normal_t predict_normal(logic [DW-1:0] d);
    longint pt[9], e0[3], e1[3], cr;
    logic [63:0] m[3], v, q, tq;
    logic [191:0] s, tgt, u, dd;
    bit neg[3], ok, pass;
    int p1, q1;
    normal_t r;
    for (int i = 0; i < 9; i++) pt[i] = longint'($signed(d[CW*i +: CW]));
    for (int i = 0; i < 3; i++) begin
      e0[i] = pt[3+i] - pt[i];
      e1[i] = pt[6+i] - pt[i];
    end
    s = '0;
    for (int i = 0; i < 3; i++) begin
      p1 = (i + 1) % 3;
      q1 = (i + 2) % 3;
      cr = e0[p1] * e1[q1] - e0[q1] * e1[p1];
      neg[i] = cr < 0;
      m[i] = neg[i] ? 64'(-cr) : 64'(cr);
      s = s + 192'(m[i]) * 192'(m[i]);
    end
    ok = s >= 192'(LOW_THR);
    pass = !ok || (s >= 192'(ONE_LO) && s <= 192'(ONE_HI));
    for (int i = 0; i < 3; i++) begin
      if (pass) begin
        v = m[i] << PASS_SHIFT;
      end else begin
        tgt = (192'(m[i]) * 192'(m[i])) << 62;
        q = '0;
        for (int b = 30; b >= 0; b--) begin
          tq = q | (64'd1 << b);
          dd = 192'(2 * tq - 1);
          u = dd * dd * s;
          if (u <= tgt) q = tq;
        end
        v = q;
      end
      if (!neg[i]) r.n[i] = (v > 64'h7FFF_FFFF) ? SAT_POS : v[31:0];
      else r.n[i] = (v > 64'h8000_0000) ? SAT_NEG : 32'(-v[31:0]);
    end
    r.ok = ok;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  task automatic add_row(int ax, int ay, int az, int bx, int by, int bz,
                         int cx, int cy, int cz, bit typed = 0,
                         int nx = 0, int ny = 0, int nz = 0, bit ok = 0);
    tri_row_t r;
    r.p = '{CW'(ax), CW'(ay), CW'(az), CW'(bx), CW'(by), CW'(bz),
            CW'(cx), CW'(cy), CW'(cz)};
    r.typed = typed;
    r.want.n = '{nx, ny, nz};
    r.want.ok = ok;
    directed.push_back(r);
  endtask

  task automatic send_tri(logic [DW-1:0] d, bit typed, normal_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    normals_due.push_back(typed ? want : predict_normal(d));
    sent_cnt++;
  endtask

  function automatic logic [DW-1:0] pack_row(tri_row_t r);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[CW*i +: CW] = r.p[i];
    return d;
  endfunction

  function automatic logic [DW-1:0] random_tri();
    int kind, base, span;
    tri_row_t r;
    kind = $urandom_range(99);
    if (kind < 40) begin
      for (int i = 0; i < 9; i++) r.p[i] = CW'($urandom);
    end else if (kind < 60) begin
      // mostly near-unit normal: each edge about 4096 along a randomly chosen axis
      for (int i = 0; i < 3; i++) r.p[i] = CW'($urandom_range(32000) - 16000);
      for (int i = 0; i < 3; i++) begin
        r.p[3+i] = CW'(r.p[i] + $urandom_range(16) - 8);
        r.p[6+i] = CW'(r.p[i] + $urandom_range(16) - 8);
      end
      base = 3 + int'($urandom_range(2));
      r.p[base] = CW'(r.p[base] + 4096);
      base = 6 + int'($urandom_range(2));
      r.p[base] = CW'(r.p[base] + 4096);
    end else if (kind < 80) begin
      span = 1 << $urandom_range(14);
      for (int i = 0; i < 3; i++) r.p[i] = CW'($urandom);
      for (int i = 3; i < 9; i++) r.p[i] = CW'(r.p[i%3] + $urandom_range(span) - span / 2);
    end else if (kind < 90) begin
      // collinear: c is a multiple of the first edge
      base = $urandom_range(3);
      for (int i = 0; i < 3; i++) begin
        r.p[i] = CW'($urandom_range(2000) - 1000);
        r.p[3+i] = CW'(r.p[i] + $urandom_range(2000) - 1000);
        r.p[6+i] = CW'(r.p[i] + base * (r.p[3+i] - r.p[i]));
      end
    end else begin
      for (int i = 0; i < 9; i++) r.p[i] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    end
    return pack_row(r);
  endfunction

  always @(posedge clk_i) begin
    normal_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      got_cnt++;
      if (normals_due.size() == 0) begin
        report("unexpected transfer", m_axis_tdata[31:0], '0);
      end else begin
        w = normals_due.pop_front();
        if (m_axis_tdata[31:0] !== w.n[0]) report("norm_x", m_axis_tdata[31:0], w.n[0]);
        if (m_axis_tdata[63:32] !== w.n[1]) report("norm_y", m_axis_tdata[63:32], w.n[1]);
        if (m_axis_tdata[95:64] !== w.n[2]) report("norm_z", m_axis_tdata[95:64], w.n[2]);
        if (m_axis_tuser !== w.ok) report("ok", 32'(m_axis_tuser), 32'(w.ok));
        if (!w.ok) degen_cnt++;
        else unit_cnt++;
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", normals_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    normal_t none;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    fail_cnt = 0;
    sent_cnt = 0;
    got_cnt = 0;
    idle_cnt = 0;
    hold_req = 1'b0;
    send_idle_pct = 36;
    recv_stall_pct = 88;
    none.n = '{0, 0, 0};
    none.ok = 1'b0;

    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 1, 0, 0, 32'h4000_0000, 1);
    add_row(0, 0, 0, 4096, 0, 0, 0, -4096, 0, 1, 0, 0, 32'hC000_0000, 1);
    add_row(0, 0, 0, 8192, 0, 0, 0, 8192, 0, 1, 0, 0, 32'h4000_0000, 1);
    add_row(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 0, 0, 64, 0);
    add_row(0, 0, 0, 1, 0, 0, 0, -1, 0, 1, 0, 0, -64, 0);
    add_row(-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32768, 1,
            0, 0, 0, 0);
    add_row(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
    add_row(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767);
    add_row(-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768);
    add_row(0, 0, 0, 4100, 3, 0, -2, 4090, 1);
    add_row(0, 0, 0, 4096, 0, 0, 0, 4097, 0);
    add_row(0, 0, 0, 4096, 0, 0, 0, 4104, 0);
    add_row(0, 0, 0, 16777, 0, 0, 0, 1, 0);
    add_row(0, 0, 0, 16777, 0, 0, 0, 2, 0);
    add_row(100, 200, 300, 101, 200, 300, 100, 201, 300);
    add_row(0, 0, 0, 0, 0, 4096, 4096, 0, 0);
    add_row(0, 0, 0, 0, 4096, 0, 0, 0, 4096);
    add_row(0, 0, 0, 1234, -567, 89, -4321, 765, -98);
    add_row(-1, -1, -1, 21845, -21846, 10922, -10923, 5461, -5462);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_tri(pack_row(directed[i]), directed[i].typed, directed[i].want);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 88;
        recv_stall_pct = 36;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
      end
      for (int n = 0; n < 480; n++) send_tri(random_tri(), 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d triangles (directed extremes, near-unit, degenerate, collinear, random);",
             sent_cnt);
    $display("checked %0d normals, %0d valid, %0d degenerate, over three idle mixes and a hold",
             got_cnt, unit_cnt, degen_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
